// ----- design/hsc_pkg.sv -----
// shared types and constants for the heapsort block with compare count
package hsc_pkg;

  localparam int DATA_W        = 32;
  localparam int POS_W         = 6;
  localparam int CNT_W         = 12;
  localparam int MAX_ITEMS_DEF = 64;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last_item;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic [POS_W-1:0]         position;
    logic                     end_of_run;
    logic [CNT_W-1:0]         compare_count;
    logic                     overflow;
  } out_word_t;

endpackage

// ----- design/hsc_mem.sv -----
// value store: one write port, one registered read port
module hsc_mem #(
  parameter int DEPTH = hsc_pkg::MAX_ITEMS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [AW-1:0]                    waddr,
  input  logic signed [hsc_pkg::DATA_W-1:0] wdata,
  input  logic                             re,
  input  logic [AW-1:0]                    raddr,
  output logic signed [hsc_pkg::DATA_W-1:0] rdata
);

  logic signed [hsc_pkg::DATA_W-1:0] store [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      store[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= store[raddr];
    end
  end

endmodule

// ----- design/hsc_ctrl.sv -----
// load, heap build, sort-down and emit sequencer around the value store
module hsc_ctrl #(
  parameter int MAX_ITEMS = hsc_pkg::MAX_ITEMS_DEF,
  parameter int AW        = $clog2(MAX_ITEMS),
  parameter int CW        = $clog2(MAX_ITEMS + 1),
  parameter int KW        = AW + 1
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  hsc_pkg::in_word_t                 in_word,
  output logic                              emit_valid,
  input  logic                              emit_ready,
  output hsc_pkg::out_word_t                emit_word,
  output logic                              we,
  output logic [AW-1:0]                     waddr,
  output logic signed [hsc_pkg::DATA_W-1:0] wdata,
  output logic                              re,
  output logic [AW-1:0]                     raddr,
  input  logic signed [hsc_pkg::DATA_W-1:0] rdata
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_BUILD  = 4'd1;
  localparam logic [3:0] S_RD_TOP = 4'd2;
  localparam logic [3:0] S_CARRY  = 4'd3;
  localparam logic [3:0] S_NEXT   = 4'd4;
  localparam logic [3:0] S_RD1    = 4'd5;
  localparam logic [3:0] S_RD2    = 4'd6;
  localparam logic [3:0] S_CMP    = 4'd7;
  localparam logic [3:0] S_SW_R0  = 4'd8;
  localparam logic [3:0] S_SW_RI  = 4'd9;
  localparam logic [3:0] S_SW_W   = 4'd10;
  localparam logic [3:0] S_EM_RD  = 4'd11;
  localparam logic [3:0] S_EM_OUT = 4'd12;

  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ITEMS);

  logic [3:0]                       state, state_next;
  logic [CW-1:0]                    count, count_next;
  logic                             ovf, ovf_next;
  logic [hsc_pkg::CNT_W-1:0]        cmp, cmp_next;
  logic [CW-1:0]                    n, n_next;
  logic [CW-1:0]                    lim, lim_next;
  logic [AW-1:0]                    idx, idx_next;
  logic                             sorting, sorting_next;
  logic [AW-1:0]                    hole, hole_next;
  logic [KW-1:0]                    child, child_next;
  logic signed [hsc_pkg::DATA_W-1:0] carried, carried_next;
  logic signed [hsc_pkg::DATA_W-1:0] cval, cval_next;
  logic signed [hsc_pkg::DATA_W-1:0] tmp, tmp_next;
  logic [AW-1:0]                    p, p_next;

  logic [KW-1:0] child_inc;
  logic [KW-1:0] lim_k;
  logic          emit_last;

  assign child_inc = child + KW'(1);
  assign lim_k     = KW'(lim);
  assign emit_last = (KW'(p) + KW'(1)) == KW'(n);

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next   = state;
    count_next   = count;
    ovf_next     = ovf;
    cmp_next     = cmp;
    n_next       = n;
    lim_next     = lim;
    idx_next     = idx;
    sorting_next = sorting;
    hole_next    = hole;
    child_next   = child;
    carried_next = carried;
    cval_next    = cval;
    tmp_next     = tmp;
    p_next       = p;
    we           = 1'b0;
    waddr        = hole;
    wdata        = carried;
    re           = 1'b0;
    raddr        = hole;
    emit_valid   = 1'b0;
    emit_word.sorted_value  = rdata;
    emit_word.position      = hsc_pkg::POS_W'(p);
    emit_word.end_of_run    = emit_last;
    emit_word.compare_count = emit_last ? cmp : '0;
    emit_word.overflow      = ovf;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (count < MAX_CNT) begin
            we         = 1'b1;
            waddr      = count[AW-1:0];
            wdata      = in_word.value;
            count_next = count + CW'(1);
          end else begin
            ovf_next = 1'b1;
          end
          if (in_word.last_item) begin
            n_next     = (count < MAX_CNT) ? count + CW'(1) : count;
            state_next = S_BUILD;
          end
        end
      end
      S_BUILD: begin
        lim_next = n;
        if (n >= CW'(2)) begin
          idx_next     = AW'((n >> 1) - CW'(1));
          hole_next    = AW'((n >> 1) - CW'(1));
          child_next   = {AW'((n >> 1) - CW'(1)), 1'b1};
          sorting_next = 1'b0;
          state_next   = S_RD_TOP;
        end else begin
          p_next     = '0;
          state_next = S_EM_RD;
        end
      end
      S_RD_TOP: begin
        re         = 1'b1;
        raddr      = hole;
        state_next = S_CARRY;
      end
      S_CARRY: begin
        carried_next = rdata;
        state_next   = S_NEXT;
      end
      S_NEXT: begin
        if (child < lim_k) begin
          re         = 1'b1;
          raddr      = child[AW-1:0];
          state_next = S_RD1;
        end else begin
          // sift finished: drop the carried word into the hole
          we    = 1'b1;
          waddr = hole;
          wdata = carried;
          if (!sorting) begin
            if (idx == '0) begin
              sorting_next = 1'b1;
              idx_next     = AW'(n - CW'(1));
              state_next   = S_SW_R0;
            end else begin
              idx_next   = idx - AW'(1);
              hole_next  = idx - AW'(1);
              child_next = {idx - AW'(1), 1'b1};
              state_next = S_RD_TOP;
            end
          end else begin
            if (idx == AW'(1)) begin
              p_next     = '0;
              state_next = S_EM_RD;
            end else begin
              idx_next   = idx - AW'(1);
              state_next = S_SW_R0;
            end
          end
        end
      end
      S_RD1: begin
        cval_next = rdata;
        if (child_inc < lim_k) begin
          re         = 1'b1;
          raddr      = child_inc[AW-1:0];
          state_next = S_RD2;
        end else begin
          state_next = S_CMP;
        end
      end
      S_RD2: begin
        if (cval < rdata) begin
          cval_next  = rdata;
          child_next = child_inc;
        end
        state_next = S_CMP;
      end
      S_CMP: begin
        if (cmp != hsc_pkg::COUNT_MAX) begin
          cmp_next = cmp + hsc_pkg::CNT_W'(1);
        end
        we    = 1'b1;
        waddr = hole;
        if (carried >= cval) begin
          wdata = carried;
          if (!sorting) begin
            if (idx == '0) begin
              sorting_next = 1'b1;
              idx_next     = AW'(n - CW'(1));
              state_next   = S_SW_R0;
            end else begin
              idx_next   = idx - AW'(1);
              hole_next  = idx - AW'(1);
              child_next = {idx - AW'(1), 1'b1};
              state_next = S_RD_TOP;
            end
          end else begin
            if (idx == AW'(1)) begin
              p_next     = '0;
              state_next = S_EM_RD;
            end else begin
              idx_next   = idx - AW'(1);
              state_next = S_SW_R0;
            end
          end
        end else begin
          wdata      = cval;
          hole_next  = child[AW-1:0];
          child_next = {child[AW-1:0], 1'b1};
          state_next = S_NEXT;
        end
      end
      S_SW_R0: begin
        re         = 1'b1;
        raddr      = '0;
        state_next = S_SW_RI;
      end
      S_SW_RI: begin
        tmp_next   = rdata;
        re         = 1'b1;
        raddr      = idx;
        state_next = S_SW_W;
      end
      S_SW_W: begin
        // root goes to the end, old end word sifts down from the root
        carried_next = rdata;
        we           = 1'b1;
        waddr        = idx;
        wdata        = tmp;
        hole_next    = '0;
        child_next   = KW'(1);
        lim_next     = CW'(idx);
        state_next   = S_NEXT;
      end
      S_EM_RD: begin
        re         = 1'b1;
        raddr      = p;
        state_next = S_EM_OUT;
      end
      S_EM_OUT: begin
        emit_valid = 1'b1;
        if (emit_ready) begin
          if (emit_last) begin
            count_next = '0;
            cmp_next   = '0;
            ovf_next   = 1'b0;
            state_next = S_IDLE;
          end else begin
            p_next     = p + AW'(1);
            state_next = S_EM_RD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      ovf   <= 1'b0;
      cmp   <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      ovf   <= ovf_next;
      cmp   <= cmp_next;
    end
  end

  always_ff @(posedge clk) begin
    n       <= n_next;
    lim     <= lim_next;
    idx     <= idx_next;
    sorting <= sorting_next;
    hole    <= hole_next;
    child   <= child_next;
    carried <= carried_next;
    cval    <= cval_next;
    tmp     <= tmp_next;
    p       <= p_next;
  end

endmodule

// ----- design/heap_sort_with_compare_count_top.sv -----
// heapsort with compare count: loads words, sorts on the last one, emits ascending
// loading: one input word per cycle while in_stall is low; the word marked last starts the sort
// sort: each sift level steps through child read, sibling read (when a sibling exists), child pick, and
//   compare and write back
// emit: each output word is read through the store read port before it is offered, then ready for the next set
// reset clears the fill count, compare count, overflow flag and handshake state; no store clearing
module heap_sort_with_compare_count_top #(
  parameter int MAX_ITEMS = hsc_pkg::MAX_ITEMS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  hsc_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output hsc_pkg::out_word_t out_word
);

  localparam int AW = $clog2(MAX_ITEMS);

  logic                              emit_valid;
  logic                              emit_ready;
  hsc_pkg::out_word_t                emit_word;
  logic                              we;
  logic [AW-1:0]                     waddr;
  logic signed [hsc_pkg::DATA_W-1:0] wdata;
  logic                              re;
  logic [AW-1:0]                     raddr;
  logic signed [hsc_pkg::DATA_W-1:0] rdata;

  hsc_mem #(
    .DEPTH (MAX_ITEMS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  hsc_ctrl #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .emit_valid (emit_valid),
    .emit_ready (emit_ready),
    .emit_word  (emit_word),
    .we         (we),
    .waddr      (waddr),
    .wdata      (wdata),
    .re         (re),
    .raddr      (raddr),
    .rdata      (rdata)
  );

  assign emit_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_valid && emit_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_valid && emit_ready) begin
      out_word <= emit_word;
    end
  end

endmodule

// ----- test/heap_sort_checker.sv -----
// checker for the heapsort block: predicts each sorted set and compares the output words
`timescale 1ns / 100ps

module heap_sort_checker #(
  parameter int MAX_ITEMS = hsc_pkg::MAX_ITEMS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  hsc_pkg::in_word_t  in_word,
  input  logic               out_valid,
  input  logic               out_stall,
  input  hsc_pkg::out_word_t out_word,
  output int                 fail_count,
  output int                 pending
);

  logic signed [hsc_pkg::DATA_W-1:0] sort_store [MAX_ITEMS];
  int unsigned                       sort_fill;
  logic [hsc_pkg::CNT_W-1:0]         sift_compares;
  logic                              set_dropped;
  hsc_pkg::out_word_t                ascending_q [$];
  int                                mismatches;

  assign fail_count = mismatches;

  task automatic sift_entry(input int unsigned top, input int unsigned n);
    logic signed [hsc_pkg::DATA_W-1:0] carried;
    int unsigned hole;
    int unsigned child;
    bit settled;
    carried = sort_store[top];
    hole = top;
    child = 2 * top + 1;
    settled = 0;
    while (!settled && child < n) begin
      if (child + 1 < n && sort_store[child] < sort_store[child + 1]) child++;
      if (sift_compares != hsc_pkg::COUNT_MAX) sift_compares++;
      if (carried >= sort_store[child]) begin
        settled = 1;
      end else begin
        sort_store[hole] = sort_store[child];
        hole = child;
        child = 2 * child + 1;
      end
    end
    sort_store[hole] = carried;
  endtask

  task automatic take_word(input hsc_pkg::in_word_t w);
    logic signed [hsc_pkg::DATA_W-1:0] t;
    hsc_pkg::out_word_t r;
    if (sort_fill < MAX_ITEMS) begin
      sort_store[sort_fill] = w.value;
      sort_fill++;
    end else begin
      set_dropped = 1'b1;
    end
    if (w.last_item) begin
      for (int i = sort_fill / 2; i > 0; i--) sift_entry(i - 1, sort_fill);
      for (int i = sort_fill - 1; i >= 1; i--) begin
        t = sort_store[i];
        sort_store[i] = sort_store[0];
        sort_store[0] = t;
        sift_entry(0, i);
      end
      for (int i = 0; i < sort_fill; i++) begin
        r.sorted_value  = sort_store[i];
        r.position      = i[hsc_pkg::POS_W-1:0];
        r.end_of_run    = (i + 1 == sort_fill);
        r.compare_count = r.end_of_run ? sift_compares : '0;
        r.overflow      = set_dropped;
        ascending_q.push_back(r);
      end
      sort_fill = 0;
      sift_compares = '0;
      set_dropped = 1'b0;
    end
  endtask

  task automatic check_word(input hsc_pkg::out_word_t got);
    hsc_pkg::out_word_t want;
    if (ascending_q.size() == 0) begin
      $error("unexpected output word: sorted_value %0d position %0d",
             got.sorted_value, got.position);
      mismatches++;
    end else begin
      want = ascending_q.pop_front();
      if (got.sorted_value !== want.sorted_value) begin
        $error("sorted_value: expected %0d, got %0d", want.sorted_value, got.sorted_value);
        mismatches++;
      end
      if (got.position !== want.position) begin
        $error("position: expected %0d, got %0d", want.position, got.position);
        mismatches++;
      end
      if (got.end_of_run !== want.end_of_run) begin
        $error("end_of_run: expected %0d, got %0d", want.end_of_run, got.end_of_run);
        mismatches++;
      end
      if (got.compare_count !== want.compare_count) begin
        $error("compare_count: expected %0d, got %0d", want.compare_count, got.compare_count);
        mismatches++;
      end
      if (got.overflow !== want.overflow) begin
        $error("overflow: expected %0d, got %0d", want.overflow, got.overflow);
        mismatches++;
      end
    end
  endtask

  initial begin
    mismatches = 0;
    sort_fill = 0;
    sift_compares = '0;
    set_dropped = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      sort_fill = 0;
      sift_compares = '0;
      set_dropped = 1'b0;
      ascending_q.delete();
    end else begin
      if (in_valid && !in_stall) take_word(in_word);
      if (out_valid && !out_stall) check_word(out_word);
    end
    pending <= ascending_q.size();
  end

endmodule

// ----- test/tb_top.sv -----
// testbench top for the heapsort block: clock, reset, word stimulus, output stalls, verdict
`timescale 1ns / 100ps

module tb_top;

  localparam int MAX_ITEMS = hsc_pkg::MAX_ITEMS_DEF;
  localparam int RANDOM_ITEMS = 450;
  localparam int HOLD_CYCLES = 300;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  hsc_pkg::in_word_t  in_word;
  logic               out_valid;
  logic               out_stall;
  hsc_pkg::out_word_t out_word;

  int fail_count;
  int pending;
  int items_sent;
  int hold_requests;
  bit tx_quiet;
  bit rx_quiet;

  heap_sort_with_compare_count_top #(.MAX_ITEMS(MAX_ITEMS)) uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  heap_sort_checker #(.MAX_ITEMS(MAX_ITEMS)) u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_word(input logic signed [hsc_pkg::DATA_W-1:0] v, input logic last);
    int gap;
    gap = tx_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= '{value: v, last_item: last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic send_set(input int stored, input int extra, input int style);
    logic signed [hsc_pkg::DATA_W-1:0] base;
    logic signed [hsc_pkg::DATA_W-1:0] step;
    logic signed [hsc_pkg::DATA_W-1:0] v;
    int total;
    base = $urandom;
    step = $urandom_range(1, 100000);
    total = stored + extra;
    for (int i = 0; i < total; i++) begin
      case (style)
        0: v = $urandom;
        1: v = $signed($urandom_range(0, 6)) - 3;
        2: v = base + i * step;
        3: v = base - i * step;
        default: v = base;
      endcase
      send_word(v, i == total - 1);
    end
  endtask

  // receiver: random stalls, plus a long hold-off when asked
  initial begin
    int stall_left;
    int hold_left;
    int holds_served;
    stall_left = 0;
    hold_left = 0;
    holds_served = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        stall_left = rx_quiet ? 0 : pick_gap();
        if (stall_left > 0) begin
          stall_left--;
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  initial begin
    logic signed [hsc_pkg::DATA_W-1:0] dir_vals [18];
    bit dir_last [18];
    int r;
    int stored;
    int extra;
    dir_vals = '{32'sh7fffffff,
                 32'sh80000000, 32'sh7fffffff,
                 5, 5, 5, 5,
                 0, -1, 32'sh7fffffff, 32'sh80000000, 1, -2,
                 4, 3, 2, 1, 0};
    dir_last = '{1, 0, 1, 0, 0, 0, 1, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 1};
    rst = 1'b1;
    in_valid = 1'b0;
    in_word = '0;
    items_sent = 0;
    hold_requests = 0;
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single value, two extremes, equal values, sign edges, reversed order
    for (int i = 0; i < 18; i++) send_word(dir_vals[i], dir_last[i]);
    drain_results();

    // long receiver hold while two sets are offered back to back
    tx_quiet = 1'b1;
    hold_requests <= hold_requests + 1;
    send_set(8, 0, 0);
    send_set(6, 0, 1);
    drain_results();

    while (items_sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 9);
      tx_quiet = (r == 0);
      rx_quiet <= (r == 1) || (r == 0);
      r = $urandom_range(0, 99);
      extra = 0;
      if (r < 70) stored = $urandom_range(1, 10);
      else if (r < 88) stored = $urandom_range(11, 40);
      else if (r < 95) stored = $urandom_range(41, MAX_ITEMS);
      else begin
        stored = MAX_ITEMS;
        extra = $urandom_range(1, 3);
      end
      send_set(stored, extra, $urandom_range(0, 4));
      if ($urandom_range(0, 7) == 0) drain_results();
    end

    drain_results();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("heap_sort_with_compare_count_top: match");
    end else begin
      $display("heap_sort_with_compare_count_top: mismatch");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("heap_sort_with_compare_count_top: mismatch");
    $finish;
  end

endmodule
